// ===== design/e2e_profile1_protect_check_unit_assert.svh =====
// assertion macros for the e2e profile 1 protect / check unit
`ifndef E2E_PROFILE1_PROTECT_CHECK_UNIT_ASSERT_SVH
`define E2E_PROFILE1_PROTECT_CHECK_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define E2EP1_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("e2ep1 assertion failed");

// next-cycle implication, disabled during reset
`define E2EP1_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("e2ep1 assertion failed");

`endif

// ===== design/e2ep1_pkg.sv =====
package e2ep1_pkg;

   // crc-8 generator polynomial, start value and highest legal alive counter
   localparam logic [7:0] CRC_POLY    = 8'h1D;
   localparam logic [7:0] CRC_START   = 8'h00;
   localparam logic [3:0] COUNTER_MAX = 4'd14;

   // configuration write data width, that of the widest register
   localparam int CSR_DATA_WIDTH = 16;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_OPERATION       = 2'd0,
      REG_DATA_IDENTIFIER = 2'd1,
      REG_ID_MODE         = 2'd2,
      REG_BUMP_COUNTER    = 2'd3
   } reg_index_type;

   // operation codes
   typedef enum logic {
      OP_PROTECT = 1'b0,
      OP_CHECK   = 1'b1
   } operation_type;

   // data-id inclusion modes
   typedef enum logic [1:0] {
      MODE_BOTH      = 2'd0,
      MODE_ALTERNATE = 2'd1,
      MODE_LOW       = 2'd2,
      MODE_NIBBLE    = 2'd3
   } mode_type;

   // position inside the frame
   typedef enum logic [1:0] {
      POS_CRC     = 2'd0,
      POS_COUNTER = 2'd1,
      POS_DATA    = 2'd2
   } pos_type;

   // result of the byte 1 stage
   typedef struct packed {
      logic [3:0] counter;
      logic [7:0] byte_one;
      logic [7:0] crc;
      logic       field_error;
   } byte_one_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] crc_value;
      logic [7:0] counter_byte;
      logic [3:0] alive_counter;
      logic       check_ok;
      logic       short_frame;
   } result_type;

   // one byte of crc-8, msb first, unrolled
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ===== design/e2ep1_if.sv =====
// frame byte channel
interface e2ep1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

// result channel
interface e2ep1_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] crc_value;
   logic [7:0] counter_byte;
   logic [3:0] alive_counter;
   logic       check_ok;
   logic       short_frame;

   modport source (output valid, output crc_value, output counter_byte,
                   output alive_counter, output check_ok, output short_frame, input ready);
   modport sink (input valid, input crc_value, input counter_byte,
                 input alive_counter, input check_ok, input short_frame, output ready);
endinterface

// ===== design/e2ep1_byte_one.sv =====
module e2ep1_byte_one
   import e2ep1_pkg::*;
(
   input  logic          [7:0]  byte_in,
   input  logic          [15:0] data_identifier,
   input  mode_type             id_mode,
   input  operation_type        operation,
   input  logic                 bump_counter,
   output byte_one_type         result
);

   logic [7:0] id_low;
   logic [7:0] id_high;
   logic [3:0] rx_counter;
   logic [3:0] counter;
   logic [3:0] counter_next;
   logic [7:0] byte_one;
   logic [7:0] prefix_crc;
   logic       nibble_error;

   assign id_low     = data_identifier[7:0];
   assign id_high    = data_identifier[15:8];
   assign rx_counter = byte_in[3:0];

   // field checks on the received byte
   assign nibble_error = (id_mode == MODE_NIBBLE) && (byte_in[7:4] != data_identifier[11:8]);

   // alive counter modulo 15
   always_comb begin
      if (rx_counter == COUNTER_MAX) begin
         counter_next = 4'd0;
      end else if (rx_counter > COUNTER_MAX) begin
         counter_next = 4'd1;
      end else begin
         counter_next = rx_counter + 4'd1;
      end
   end

   // byte 1 rewrite in protect mode
   always_comb begin
      counter  = rx_counter;
      byte_one = byte_in;
      if (operation == OP_PROTECT) begin
         if (bump_counter) begin
            counter       = counter_next;
            byte_one[3:0] = counter_next;
         end
         if (id_mode == MODE_NIBBLE) begin
            byte_one[7:4] = data_identifier[11:8];
         end
      end
   end

   // data-id prefix
   always_comb begin
      case (id_mode)
         MODE_BOTH: begin
            prefix_crc = crc8_update(crc8_update(CRC_START, id_low), id_high);
         end
         MODE_ALTERNATE: begin
            prefix_crc = crc8_update(CRC_START, counter[0] ? id_high : id_low);
         end
         MODE_LOW: begin
            prefix_crc = crc8_update(CRC_START, id_low);
         end
         default: begin
            prefix_crc = crc8_update(crc8_update(CRC_START, id_low), 8'h00);
         end
      endcase
   end

   assign result.counter     = counter;
   assign result.byte_one    = byte_one;
   assign result.crc         = crc8_update(prefix_crc, byte_one);
   assign result.field_error = (rx_counter > COUNTER_MAX) || nibble_error;

endmodule

// ===== design/e2e_profile1_protect_check_unit.sv =====
// E2E profile 1 protect / check: takes a frame one byte per transaction on req_ch (byte 0
// is the received crc, byte 1 carries the alive counter, frame_last ends the frame) and
// gives one rsp_ch transaction per frame, registered after its last byte, with the crc-8
// over the data-id prefix and bytes 1..last. A byte is taken every cycle unless stalled;
// one byte's crc, and for byte 1 the prefix plus byte, is combinational. Results leave
// through an output register backed by a one-entry skid buffer, so req_ch.ready drops only
// while both are full. Configuration writes on csr_* take effect on the next byte.
module e2e_profile1_protect_check_unit
   import e2ep1_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   e2ep1_req_if.sink                 req_ch,
   e2ep1_rsp_if.source               rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wr_data
);

`include "e2e_profile1_protect_check_unit_assert.svh"

   // configuration registers
   operation_type operation_ff;
   logic [15:0]   data_identifier_ff;
   mode_type      id_mode_ff;
   logic          bump_counter_ff;

   // frame state
   pos_type    pos_ff, pos_in;
   logic [7:0] running_crc_ff, running_crc_in;
   logic [7:0] received_crc_ff, received_crc_in;
   logic [3:0] held_counter_ff, held_counter_in;
   logic [7:0] held_byte_one_ff, held_byte_one_in;
   logic       field_error_ff, field_error_in;

   // output register and skid
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic         accept;
   logic         take;
   logic         produce;
   result_type   new_result;
   byte_one_type byte_one;
   logic [7:0]   frame_crc;
   logic         frame_error;

   assign accept = req_ch.valid && req_ch.ready;
   assign take   = rsp_ch.valid && rsp_ch.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff       <= OP_PROTECT;
         data_identifier_ff <= '0;
         id_mode_ff         <= MODE_BOTH;
         bump_counter_ff    <= 1'b1;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_OPERATION:       operation_ff       <= operation_type'(csr_wr_data[0]);
            REG_DATA_IDENTIFIER: data_identifier_ff <= csr_wr_data[15:0];
            REG_ID_MODE:         id_mode_ff         <= mode_type'(csr_wr_data[1:0]);
            REG_BUMP_COUNTER:    bump_counter_ff    <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // byte 1 handling and prefix crc
   e2ep1_byte_one u_byte_one (
      .byte_in         (req_ch.frame_byte),
      .data_identifier (data_identifier_ff),
      .id_mode         (id_mode_ff),
      .operation       (operation_ff),
      .bump_counter    (bump_counter_ff),
      .result          (byte_one)
   );

   // next frame state
   always_comb begin
      pos_in           = pos_ff;
      running_crc_in   = running_crc_ff;
      received_crc_in  = received_crc_ff;
      held_counter_in  = held_counter_ff;
      held_byte_one_in = held_byte_one_ff;
      field_error_in   = field_error_ff;
      if (accept) begin
         case (pos_ff)
            POS_CRC: begin
               received_crc_in = req_ch.frame_byte;
               pos_in          = req_ch.frame_last ? POS_CRC : POS_COUNTER;
            end
            POS_COUNTER: begin
               held_counter_in  = byte_one.counter;
               held_byte_one_in = byte_one.byte_one;
               field_error_in   = byte_one.field_error;
               running_crc_in   = byte_one.crc;
               pos_in           = req_ch.frame_last ? POS_CRC : POS_DATA;
            end
            default: begin
               running_crc_in = frame_crc;
               pos_in         = req_ch.frame_last ? POS_CRC : POS_DATA;
            end
         endcase
      end
   end

   // result of the current byte
   always_comb begin
      frame_crc   = (pos_ff == POS_COUNTER) ? byte_one.crc
                                            : crc8_update(running_crc_ff, req_ch.frame_byte);
      frame_error = (pos_ff == POS_COUNTER) ? byte_one.field_error : field_error_ff;
      produce     = accept && req_ch.frame_last;
      new_result  = '0;
      case (pos_ff)
         POS_CRC: begin
            new_result.short_frame = 1'b1;
         end
         POS_COUNTER: begin
            new_result.crc_value     = frame_crc;
            new_result.counter_byte  = byte_one.byte_one;
            new_result.alive_counter = byte_one.counter;
         end
         default: begin
            new_result.crc_value     = frame_crc;
            new_result.counter_byte  = held_byte_one_ff;
            new_result.alive_counter = held_counter_ff;
         end
      endcase
      if (pos_ff != POS_CRC) begin
         new_result.check_ok = (operation_ff == OP_CHECK) && !frame_error
                               && (frame_crc == received_crc_ff);
      end
   end

   // output register with skid buffer
   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = new_result;
            skid_valid_in = produce;
         end else begin
            main_in       = new_result;
            main_valid_in = produce;
         end
      end else if (produce) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= POS_CRC;
         running_crc_ff   <= '0;
         received_crc_ff  <= '0;
         held_counter_ff  <= '0;
         held_byte_one_ff <= '0;
         field_error_ff   <= 1'b0;
         main_valid_ff    <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         running_crc_ff   <= running_crc_in;
         received_crc_ff  <= received_crc_in;
         held_counter_ff  <= held_counter_in;
         held_byte_one_ff <= held_byte_one_in;
         field_error_ff   <= field_error_in;
         main_valid_ff    <= main_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // channel outputs
   assign req_ch.ready         = !skid_valid_ff;
   assign rsp_ch.valid         = main_valid_ff;
   assign rsp_ch.crc_value     = main_ff.crc_value;
   assign rsp_ch.counter_byte  = main_ff.counter_byte;
   assign rsp_ch.alive_counter = main_ff.alive_counter;
   assign rsp_ch.check_ok      = main_ff.check_ok;
   assign rsp_ch.short_frame   = main_ff.short_frame;

   // assertions
   `E2EP1_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `E2EP1_ASSERT_NOW(a_short_frame_clean, clock, reset, rsp_ch.valid && rsp_ch.short_frame, (rsp_ch.crc_value == 8'h00) && !rsp_ch.check_ok)
   `E2EP1_ASSERT_NEXT(a_last_ends_frame, clock, reset, accept && req_ch.frame_last, pos_ff == POS_CRC)
   `E2EP1_ASSERT_NEXT(a_last_gives_result, clock, reset, accept && req_ch.frame_last, main_valid_ff)

endmodule

// ===== tb/e2e_profile1_protect_check_unit_test.sv =====
`timescale 1ns / 1ps

module e2e_profile1_protect_check_unit_test
   import e2ep1_pkg::*;
;

   // frame-level crc-8 prediction for the protect / check unit
   class e2e_frame_predictor;

      // register copy
      operation_type operation;
      logic [15:0]   data_id;
      mode_type      id_mode;
      logic          bump;

      // frame state
      pos_type       position;
      logic [7:0]    running_crc;
      logic [7:0]    received_crc;
      logic [3:0]    held_counter;
      logic [7:0]    held_byte_one;
      logic          field_error;

      result_type    expected_results[$];
      int            errors;

      function new();
         operation     = OP_PROTECT;
         data_id       = 16'h0000;
         id_mode       = MODE_BOTH;
         bump          = 1'b1;
         position      = POS_CRC;
         running_crc   = 8'h00;
         received_crc  = 8'h00;
         held_counter  = 4'h0;
         held_byte_one = 8'h00;
         field_error   = 1'b0;
         errors        = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [15:0] value);
         case (idx)
            REG_OPERATION:       operation = operation_type'(value[0]);
            REG_DATA_IDENTIFIER: data_id = value;
            REG_ID_MODE:         id_mode = mode_type'(value[1:0]);
            default:             bump = value[0];
         endcase
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // bit-serial crc-8, msb first
      function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] data);
         logic [7:0] r;
         logic       feedback;
         r = crc;
         for (int i = 7; i >= 0; i--) begin
            feedback = r[7] ^ data[i];
            r = {r[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
         end
         return r;
      endfunction

      // crc over the data-id prefix for the current mode
      function logic [7:0] id_prefix(logic [3:0] counter);
         case (id_mode)
            MODE_BOTH:      return crc_step(crc_step(CRC_START, data_id[7:0]), data_id[15:8]);
            MODE_ALTERNATE: return crc_step(CRC_START, counter[0] ? data_id[15:8] : data_id[7:0]);
            MODE_LOW:       return crc_step(CRC_START, data_id[7:0]);
            default:        return crc_step(crc_step(CRC_START, data_id[7:0]), 8'h00);
         endcase
      endfunction

      // crc a receiver would accept for this frame, byte 1 taken as is
      function logic [7:0] seal_crc(input logic [7:0] frame[$]);
         logic [7:0] c;
         c = crc_step(id_prefix(frame[1][3:0]), frame[1]);
         for (int i = 2; i < frame.size(); i++) begin
            c = crc_step(c, frame[i]);
         end
         return c;
      endfunction

      function void note_frame_byte(logic [7:0] b, logic last);
         result_type r;
         logic [3:0] counter;
         logic [7:0] byte_one;
         int         bumped;
         r = '0;
         case (position)
            // crc byte, or a frame that ends right there
            POS_CRC: begin
               received_crc = b;
               if (last) begin
                  r.short_frame = 1'b1;
                  expected_results.push_back(r);
               end else begin
                  position = POS_COUNTER;
               end
               return;
            end
            // byte 1: field checks, counter bump, nibble insert, prefix
            POS_COUNTER: begin
               counter  = b[3:0];
               byte_one = b;
               field_error = (counter > COUNTER_MAX) ||
                             (id_mode == MODE_NIBBLE && b[7:4] != data_id[11:8]);
               if (operation == OP_PROTECT) begin
                  if (bump) begin
                     bumped = (int'(counter) + 1) % (int'(COUNTER_MAX) + 1);
                     counter = bumped[3:0];
                     byte_one[3:0] = counter;
                  end
                  if (id_mode == MODE_NIBBLE) begin
                     byte_one[7:4] = data_id[11:8];
                  end
               end
               held_counter  = counter;
               held_byte_one = byte_one;
               running_crc   = crc_step(id_prefix(counter), byte_one);
               position      = POS_DATA;
            end
            default: begin
               running_crc = crc_step(running_crc, b);
            end
         endcase
         if (last) begin
            r.crc_value     = running_crc;
            r.counter_byte  = held_byte_one;
            r.alive_counter = held_counter;
            r.check_ok      = (operation == OP_CHECK) && !field_error &&
                              (running_crc == received_crc);
            expected_results.push_back(r);
            position = POS_CRC;
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $error("result with no frame outstanding: crc 'h%0h", got.crc_value);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("crc_value", want.crc_value, got.crc_value);
         compare_field("counter_byte", want.counter_byte, got.counter_byte);
         compare_field("alive_counter", want.alive_counter, got.alive_counter);
         compare_field("check_ok", want.check_ok, got.check_ok);
         compare_field("short_frame", want.short_frame, got.short_frame);
      endfunction
   endclass

   localparam int LONG_HOLD    = 150;
   localparam int ITEMS_PER_CFG = 41;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   e2ep1_req_if req_ch ();
   e2ep1_rsp_if rsp_ch ();

   e2e_frame_predictor predictor = new();

   logic [7:0] frame_bytes[$];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_requests = 0;
   int         holds_served  = 0;
   int         hold_left     = 0;

   e2e_profile1_protect_check_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure, with a long hold on request
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // observe accepted transactions and register writes
   always @(posedge clock) begin : bus_monitor
      result_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            predictor.note_frame_byte(req_ch.frame_byte, req_ch.frame_last);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.crc_value, rsp_ch.counter_byte, rsp_ch.alive_counter,
                    rsp_ch.check_ok, rsp_ch.short_frame};
            predictor.check_result(seen);
         end
         if (csr_wr_en) begin
            predictor.set_reg(reg_index_type'(csr_index), csr_wr_data);
         end
      end
   end

   // offer one byte, idling at random first
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.frame_byte <= b;
      req_ch.frame_last <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   // stop offering until every result is back, then let the pipe empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (predictor.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_config(operation_type op, logic [15:0] id, mode_type mode,
                             logic bump);
      logic [15:0] values[4];
      values[REG_OPERATION]       = 16'(op);
      values[REG_DATA_IDENTIFIER] = id;
      values[REG_ID_MODE]         = 16'(mode);
      values[REG_BUMP_COUNTER]    = 16'(bump);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= reg_index_type'(i);
         csr_wr_data <= values[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_config();
      logic [15:0] id;
      case ($urandom_range(3))
         0:       id = 16'h0000;
         1:       id = 16'hFFFF;
         default: id = 16'($urandom_range(16'hFFFF));
      endcase
      set_config(operation_type'($urandom_range(1)), id, mode_type'($urandom_range(3)),
                 1'($urandom_range(1)));
   endtask

   // random frame; in check mode mostly well-formed, some with one defect
   task automatic build_frame();
      int         len;
      logic [7:0] byte_one;
      logic [7:0] tail;
      if ($urandom_range(99) < 5) begin
         len = 1;
      end else if ($urandom_range(99) < 8) begin
         len = $urandom_range(20, 7);
      end else begin
         len = $urandom_range(5, 2);
      end
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
      if (predictor.operation == OP_CHECK && len >= 2 && $urandom_range(99) < 75) begin
         byte_one = frame_bytes[1];
         byte_one[3:0] = 4'($urandom_range(COUNTER_MAX));
         if (predictor.id_mode == MODE_NIBBLE) begin
            byte_one[7:4] = predictor.data_id[11:8];
         end
         frame_bytes[1] = byte_one;
         frame_bytes[0] = predictor.seal_crc(frame_bytes);
         case ($urandom_range(9))
            0: frame_bytes[0] = frame_bytes[0] ^ (8'h01 << $urandom_range(7));
            1: begin
               tail = frame_bytes[len - 1] ^ (8'h01 << $urandom_range(7));
               frame_bytes[len - 1] = tail;
            end
            2: begin
               byte_one[3:0] = 4'hF;
               frame_bytes[1] = byte_one;
            end
            default: ;
         endcase
      end
   endtask

   // end the run if it hangs
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int items;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.frame_byte = 8'h00;
      req_ch.frame_last = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = REG_OPERATION;
      csr_wr_data       = 16'h0000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: protect, counter wrap at 14, counter 15, short frame
      frame_bytes = '{8'hFF};
      send_frame();
      frame_bytes = '{8'h00, 8'h0E, 8'hFF};
      send_frame();
      frame_bytes = '{8'h5A, 8'h0F, 8'h00};
      send_frame();

      // check with nibble mode: good frame, counter 15, nibble mismatch, short
      settle();
      set_config(OP_CHECK, 16'hFFFF, MODE_NIBBLE, 1'b0);
      frame_bytes = '{8'h00, 8'hF3};
      frame_bytes[0] = predictor.seal_crc(frame_bytes);
      send_frame();
      frame_bytes = '{8'h00, 8'hFF, 8'h80};
      frame_bytes[0] = predictor.seal_crc(frame_bytes);
      send_frame();
      frame_bytes = '{8'h00, 8'h73, 8'h11};
      frame_bytes[0] = predictor.seal_crc(frame_bytes);
      send_frame();
      frame_bytes = '{8'h00};
      send_frame();

      // alternating prefix, odd and even counter after the bump
      settle();
      set_config(OP_PROTECT, 16'h1234, MODE_ALTERNATE, 1'b1);
      frame_bytes = '{8'h00, 8'h01, 8'hAA};
      send_frame();
      frame_bytes = '{8'h00, 8'h02, 8'h55};
      send_frame();

      // low byte prefix in check mode
      settle();
      set_config(OP_CHECK, 16'h0000, MODE_LOW, 1'b1);
      frame_bytes = '{8'h00, 8'h80};
      frame_bytes[0] = predictor.seal_crc(frame_bytes);
      send_frame();

      // random frames under three idle profiles and several settings each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct <= 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct <= 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int setting = 0; setting < 6; setting++) begin
            settle();
            random_config();
            // stall the results while frames of one or two bytes keep coming
            if (phase == 2 && setting == 0) begin
               hold_requests <= hold_requests + 1;
               repeat (40) begin
                  frame_bytes.delete();
                  repeat ($urandom_range(2, 1)) frame_bytes.push_back(8'($urandom_range(255)));
                  send_frame();
               end
            end
            items = 0;
            while (items < ITEMS_PER_CFG) begin
               build_frame();
               items += frame_bytes.size();
               send_frame();
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (predictor.errors == 0 && predictor.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+design
design/e2ep1_pkg.sv
design/e2ep1_if.sv
design/e2ep1_byte_one.sv
design/e2e_profile1_protect_check_unit.sv
tb/e2e_profile1_protect_check_unit_test.sv
